### rtl/ggpf_pkg.sv
// ggpf_pkg: shared constants, types and helpers for the glyph to gray page formatter
// used by every interface and module of the block but ggpf_ram; depends on nothing

package ggpf_pkg;

  // default sizes of the line buffer and the glyph
  localparam int unsigned MAX_WIDTH_DEF  = 63;
  localparam int unsigned MAX_HEIGHT_DEF = 64;

  // fixed field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned COL_W     = 6;
  localparam int unsigned HEIGHT_W  = 7;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 7;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_WIDTH   = 2'd0,
    REG_GLYPH_HEIGHT  = 2'd1,
    REG_INVERT_ENABLE = 2'd2,
    REG_MASK_ENABLE   = 2'd3
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic [COL_W-1:0]    WIDTH_RESET  = 6'd8;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd8;

  // two-bit pixel patterns
  localparam logic [BYTE_W-1:0] PIX0 = 8'h03;
  localparam logic [BYTE_W-1:0] PIX1 = 8'h0C;
  localparam logic [BYTE_W-1:0] PIX2 = 8'h30;
  localparam logic [BYTE_W-1:0] PIX3 = 8'hC0;

  // controller commands to the datapath
  typedef struct packed {
    logic take;       // input request may be taken
    logic read;       // issue line buffer read
    logic load_high;  // load buffered page byte into output register
  } ggpf_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic in_valid;    // input request pending
    logic out_free;    // output register can be loaded
    logic two_end;     // current byte ends a row that sends two pages
    logic drain_last;  // drain index at the last column
  } ggpf_status_t;

  // widen a nibble: each set bit becomes 11
  function automatic logic [BYTE_W-1:0] widen_nibble(input logic [NIBBLE_W-1:0] n);
    logic [BYTE_W-1:0] r;
    r = '0;
    if (n[0]) r = r | PIX0;
    if (n[1]) r = r | PIX1;
    if (n[2]) r = r | PIX2;
    if (n[3]) r = r | PIX3;
    return r;
  endfunction

endpackage

### rtl/ggpf_in_if.sv
// ggpf_in_if: input channel carrying one glyph column byte and its mask byte
// depends on ggpf_pkg

interface ggpf_in_if import ggpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] glyph_byte;
  logic [BYTE_W-1:0] mask_byte;

  modport source (output valid, output glyph_byte, output mask_byte, input ready);
  modport sink   (input valid, input glyph_byte, input mask_byte, output ready);
endinterface

### rtl/ggpf_out_if.sv
// ggpf_out_if: output channel carrying one display byte and its end flags
// depends on ggpf_pkg

interface ggpf_out_if import ggpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_pair_byte;
  logic              end_of_transfer;
  logic              end_of_glyph;

  modport source (output valid, output pixel_pair_byte, output end_of_transfer,
                  output end_of_glyph, input ready);
  modport sink   (input valid, input pixel_pair_byte, input end_of_transfer,
                  input end_of_glyph, output ready);
endinterface

### rtl/ggpf_cfg_if.sv
// ggpf_cfg_if: configuration write channel, register index and write data
// depends on ggpf_pkg

interface ggpf_cfg_if import ggpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

### rtl/ggpf_ram.sv
// ggpf_ram: generic single write port, single read port RAM with registered read
// depends on nothing

module ggpf_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 63,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ggpf_ctrl.sv
// ggpf_ctrl: state machine sequencing request intake and the second page drain
// depends on ggpf_pkg

module ggpf_ctrl import ggpf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ggpf_status_t status,
  output ggpf_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_INTAKE = 3'b001,
    S_READ   = 3'b010,
    S_LOAD   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd.take      = 1'b0;
    cmd.read      = 1'b0;
    cmd.load_high = 1'b0;
    case (state)
      S_INTAKE: begin
        cmd.take = status.out_free;
        if (status.in_valid && status.out_free && status.two_end) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_high = 1'b1;
          state_next    = status.drain_last ? S_INTAKE : S_READ;
        end
      end
      default: begin
        state_next = S_INTAKE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INTAKE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/ggpf_datapath.sv
// ggpf_datapath: configuration registers, counters, inversion, line buffer and output register
// depends on ggpf_pkg, ggpf_ram and the channel interfaces

module ggpf_datapath import ggpf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ggpf_in_if.sink      glyph_in,
  ggpf_out_if.source   page_out,
  ggpf_cfg_if.sink     cfg,
  input  ggpf_cmd_t    cmd,
  output ggpf_status_t status
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration registers
  logic [COL_W-1:0]    glyph_width;
  logic [HEIGHT_W-1:0] glyph_height;
  logic                invert_enable;
  logic                mask_enable;

  // counters and drain state
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] byte_row_count;
  logic [COL_W-1:0] drain_idx;
  logic             drain_last_row;

  // output register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_eot;
  logic              out_eog;

  // derived values
  logic [COL_W-1:0]    w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [ROW_W:0]      rows;
  logic [4:0]          pages;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;
  logic                two;
  logic                last_row;
  logic                last_col;
  logic [BYTE_W-1:0]   s;
  logic                accept;
  logic [NIBBLE_W-1:0] rdata;

  // configuration writes, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width   <= WIDTH_RESET;
      glyph_height  <= HEIGHT_RESET;
      invert_enable <= 1'b0;
      mask_enable   <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.reg_index))
        REG_GLYPH_WIDTH:   glyph_width   <= cfg.reg_data[COL_W-1:0];
        REG_GLYPH_HEIGHT:  glyph_height  <= cfg.reg_data[HEIGHT_W-1:0];
        REG_INVERT_ENABLE: invert_enable <= cfg.reg_data[0];
        REG_MASK_ENABLE:   mask_enable   <= cfg.reg_data[0];
        default: ;
      endcase
    end
  end

  // clamp sizes, count byte rows and pages
  always_comb begin
    if (glyph_width == '0) begin
      w_eff = COL_W'(1);
    end else if (glyph_width > COL_W'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = glyph_width;
    end
    if (glyph_height == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (glyph_height > HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = glyph_height;
    end
    rows  = (ROW_W+1)'((h_eff + HEIGHT_W'(7)) >> 3);
    pages = 5'((h_eff + HEIGHT_W'(3)) >> 2);
  end

  // position of the current byte, restarted if beyond a shrunken size
  always_comb begin
    col      = (column_count >= w_eff) ? '0 : column_count;
    row      = ({1'b0, byte_row_count} >= rows) ? '0 : byte_row_count;
    two      = ({1'b0, row, 1'b0} + 5'd2) <= pages;
    last_row = ({1'b0, row} + (ROW_W+1)'(1)) == rows;
    last_col = ({1'b0, col} + (COL_W+1)'(1)) == {1'b0, w_eff};
  end

  // inversion
  always_comb begin
    s = glyph_in.glyph_byte;
    if (invert_enable) begin
      s = mask_enable ? (glyph_in.glyph_byte ^ glyph_in.mask_byte) : ~glyph_in.glyph_byte;
    end
  end

  assign glyph_in.ready = cmd.take;
  assign accept         = cmd.take & glyph_in.valid;

  // status to the controller
  assign status.in_valid   = glyph_in.valid;
  assign status.out_free   = ~out_valid | page_out.ready;
  assign status.two_end    = last_col & two;
  assign status.drain_last = ({1'b0, drain_idx} + (COL_W+1)'(1)) == {1'b0, w_eff};

  // line buffer of high nibbles
  ggpf_ram #(
    .WIDTH (NIBBLE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (accept),
    .waddr (col[AW-1:0]),
    .wdata (s[BYTE_W-1:NIBBLE_W]),
    .re    (cmd.read),
    .raddr (drain_idx[AW-1:0]),
    .rdata (rdata)
  );

  // column and byte row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      byte_row_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count   <= '0;
        byte_row_count <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        column_count   <= col + COL_W'(1);
        byte_row_count <= row;
      end
    end
  end

  // drain index over the buffered columns
  always_ff @(posedge clk) begin
    if (accept) begin
      drain_idx      <= '0;
      drain_last_row <= last_row;
    end else if (cmd.load_high) begin
      drain_idx <= drain_idx + COL_W'(1);
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept || cmd.load_high) begin
      out_valid <= 1'b1;
    end else if (page_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload: low page byte or buffered high page byte
  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte <= widen_nibble(s[NIBBLE_W-1:0]);
      out_eot  <= last_col & ~two;
      out_eog  <= last_col & ~two & last_row;
    end else if (cmd.load_high) begin
      out_byte <= widen_nibble(rdata);
      out_eot  <= status.drain_last;
      out_eog  <= status.drain_last & drain_last_row;
    end
  end

  assign page_out.valid           = out_valid;
  assign page_out.pixel_pair_byte = out_byte;
  assign page_out.end_of_transfer = out_eot;
  assign page_out.end_of_glyph    = out_eog;

endmodule

### rtl/glyph_to_gray_page_formatter.sv
// glyph_to_gray_page_formatter: each request gives its low page byte in the cycle after acceptance;
// a request is taken every cycle while the output register drains and no line buffer drain runs.
// at the last column of a byte row sending two pages the line buffer drains after it:
// each buffered column is a RAM read, then an output load once the output register is free.
// reset (rst, synchronous) restores register defaults, clears counters and output valid;
// the line buffer is not cleared and needs no sweep
// depends on ggpf_pkg, the channel interfaces, ggpf_ctrl and ggpf_datapath

module glyph_to_gray_page_formatter import ggpf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ggpf_in_if.sink    glyph_in,
  ggpf_out_if.source page_out,
  ggpf_cfg_if.sink   cfg
);

  ggpf_cmd_t    cmd;
  ggpf_status_t status;

  // sequencing
  ggpf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // data handling
  ggpf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .glyph_in (glyph_in),
    .page_out (page_out),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

### verif/ggpf_check_pkg.sv
`timescale 1ns / 1ps
// ggpf_check_pkg: gray page tracker, the expected display bytes for the formatter
// depends on ggpf_pkg for field widths, reset values and register indexes

package ggpf_check_pkg;
  import ggpf_pkg::*;

  class gray_page_tracker;
    typedef struct packed {
      logic [BYTE_W-1:0] pixels;
      logic              last_of_transfer;
      logic              last_of_glyph;
    } page_byte_t;

    logic [COL_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                invert_on;
    logic                mask_on;
    int unsigned         column_pos;
    int unsigned         byte_row_pos;
    logic [NIBBLE_W-1:0] high_nibbles [MAX_WIDTH_DEF];
    page_byte_t          expected_bytes [$];
    int unsigned         mismatch_count;

    function new();
      width_reg      = WIDTH_RESET;
      height_reg     = HEIGHT_RESET;
      invert_on      = 1'b0;
      mask_on        = 1'b0;
      column_pos     = 0;
      byte_row_pos   = 0;
      mismatch_count = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_GLYPH_WIDTH:   width_reg  = data[COL_W-1:0];
        REG_GLYPH_HEIGHT:  height_reg = data[HEIGHT_W-1:0];
        REG_INVERT_ENABLE: invert_on  = data[0];
        REG_MASK_ENABLE:   mask_on    = data[0];
        default: ;
      endcase
    endfunction

    // each set pixel becomes a pair of ones
    function logic [BYTE_W-1:0] spread_nibble(logic [NIBBLE_W-1:0] n);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < NIBBLE_W; i++) r[2*i +: 2] = {2{n[i]}};
      return r;
    endfunction

    function void push_byte(logic [BYTE_W-1:0] pixels, logic eot, logic eog);
      page_byte_t b;
      b.pixels           = pixels;
      b.last_of_transfer = eot;
      b.last_of_glyph    = eog;
      expected_bytes.push_back(b);
    endfunction

    // accepted request: expected page bytes and the new counter state
    function void note_glyph_byte(logic [BYTE_W-1:0] glyph, logic [BYTE_W-1:0] mask);
      int unsigned         w, h, rows, pages, col, row;
      logic [BYTE_W-1:0]   s;
      logic                two, last_row;
      w = (width_reg == 0) ? 1 : width_reg;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      h = (height_reg == 0) ? 1 : height_reg;
      if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
      rows  = (h + 7) / 8;
      pages = (h + 3) / 4;
      col = (column_pos >= w) ? 0 : column_pos;
      row = (byte_row_pos >= rows) ? 0 : byte_row_pos;

      s = glyph;
      if (invert_on) s = mask_on ? (s ^ mask) : ~s;
      two      = (2 * row + 2) <= pages;
      last_row = (row + 1) == rows;
      high_nibbles[col] = s[7:4];

      // ordinary column
      if (col + 1 < w) begin
        push_byte(spread_nibble(s[3:0]), 1'b0, 1'b0);
        column_pos   = col + 1;
        byte_row_pos = row;
        return;
      end

      // row end: low page byte, then the buffered high page when it is due
      if (two) begin
        push_byte(spread_nibble(s[3:0]), 1'b0, 1'b0);
        for (int c = 0; c < w; c++)
          push_byte(spread_nibble(high_nibbles[c]), c + 1 == w, (c + 1 == w) && last_row);
      end else begin
        push_byte(spread_nibble(s[3:0]), 1'b1, last_row);
      end
      column_pos   = 0;
      byte_row_pos = last_row ? 0 : row + 1;
    endfunction

    function void check_page_byte(logic [BYTE_W-1:0] pixels, logic eot, logic eog);
      page_byte_t want;
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected page byte %h eot %b eog %b", $time, pixels, eot, eog);
        return;
      end
      want = expected_bytes.pop_front();
      if (want.pixels !== pixels || want.last_of_transfer !== eot ||
          want.last_of_glyph !== eog) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: page byte mismatch, expected %h eot %b eog %b, got %h eot %b eog %b",
                   $time, want.pixels, want.last_of_transfer, want.last_of_glyph,
                   pixels, eot, eog);
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

endpackage

### verif/tb_glyph_to_gray_page_formatter.sv
`timescale 1ns / 1ps
// tb_glyph_to_gray_page_formatter: directed and random glyph bytes through the formatter,
// every display byte checked against the gray page tracker; depends on ggpf_pkg,
// the channel interfaces, ggpf_check_pkg and glyph_to_gray_page_formatter

module tb_glyph_to_gray_page_formatter;
  import ggpf_pkg::*;
  import ggpf_check_pkg::*;

  localparam int unsigned RANDOM_ITEMS     = 370;
  localparam int unsigned CALM_TAIL        = 60;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT      = 2_000_000;

  logic clk;
  logic rst;

  ggpf_in_if  glyph_in ();
  ggpf_out_if page_out ();
  ggpf_cfg_if cfg ();

  gray_page_tracker tracker;
  bit               calm;
  bit               hold_request;
  int unsigned      cycle_count;

  glyph_to_gray_page_formatter DUT (
    .clk      (clk),
    .rst      (rst),
    .glyph_in (glyph_in),
    .page_out (page_out),
    .cfg      (cfg)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // accepted requests, register writes and page bytes, all in one place
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready)
        tracker.set_register(cfg_reg_t'(cfg.reg_index), cfg.reg_data);
      if (glyph_in.valid && glyph_in.ready)
        tracker.note_glyph_byte(glyph_in.glyph_byte, glyph_in.mask_byte);
      if (page_out.valid && page_out.ready)
        tracker.check_page_byte(page_out.pixel_pair_byte, page_out.end_of_transfer,
                                page_out.end_of_glyph);
    end
  end

  // receiver: random stalls, one long hold-off on demand
  initial begin
    page_out.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        page_out.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        page_out.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        page_out.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // one glyph byte request, with an occasional idle burst in front
  task automatic offer_byte(input logic [BYTE_W-1:0] g, input logic [BYTE_W-1:0] m);
    if (!calm && !hold_request && $urandom_range(0, 5) == 0) begin
      glyph_in.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    glyph_in.valid      <= 1'b1;
    glyph_in.glyph_byte <= g;
    glyph_in.mask_byte  <= m;
    do @(posedge clk); while (!glyph_in.ready);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] data);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.reg_data  <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // all four registers, only while the block is idle
  task automatic apply_settings(input logic [CFG_DAT_W-1:0] width_data,
                                input logic [CFG_DAT_W-1:0] height_data,
                                input logic [CFG_DAT_W-1:0] invert_data,
                                input logic [CFG_DAT_W-1:0] mask_data);
    write_register(REG_GLYPH_WIDTH, width_data);
    write_register(REG_GLYPH_HEIGHT, height_data);
    write_register(REG_INVERT_ENABLE, invert_data);
    write_register(REG_MASK_ENABLE, mask_data);
    cfg.valid <= 1'b0;
  endtask

  // stop sending and wait for every expected page byte
  task automatic settle();
    glyph_in.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned random_items, phase, count, w, h, rows, pick;
    logic [CFG_DAT_W-1:0] width_data, height_data;

    tracker      = new();
    calm         = 1'b0;
    hold_request = 1'b0;
    rst                 <= 1'b1;
    glyph_in.valid      <= 1'b0;
    glyph_in.glyph_byte <= '0;
    glyph_in.mask_byte  <= '0;
    cfg.valid           <= 1'b0;
    cfg.reg_index       <= REG_GLYPH_WIDTH;
    cfg.reg_data        <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: one byte row, two pages, extremes of the byte
    offer_byte(8'h00, 8'hFF);
    offer_byte(8'hFF, 8'h00);
    offer_byte(8'h0F, 8'hA5);
    offer_byte(8'hF0, 8'h5A);
    offer_byte(8'hA5, 8'hFF);
    offer_byte(8'h5A, 8'h00);
    offer_byte(8'h01, 8'h80);
    offer_byte(8'h80, 8'h01);
    settle();

    // smallest glyph, full complement
    apply_settings(7'd1, 7'd1, 7'd1, 7'd0);
    offer_byte(8'h3C, 8'hFF);
    settle();

    // zero width and zero height, mask inversion, top bit of the width write set
    apply_settings(7'h40, 7'd0, 7'd1, 7'd1);
    offer_byte(8'hFF, 8'h0F);
    settle();

    // leave the column counter part way through a row
    apply_settings(7'd4, 7'd4, 7'd0, 7'd0);
    offer_byte(8'h12, 8'h00);
    offer_byte(8'h34, 8'h00);
    offer_byte(8'h56, 8'h00);
    settle();

    // narrower width restarts the column; last byte row sends one page only
    apply_settings(7'd2, 7'd12, 7'd1, 7'd1);
    offer_byte(8'hC3, 8'hF0);
    offer_byte(8'h3C, 8'h0F);
    offer_byte(8'h99, 8'hFF);
    offer_byte(8'h66, 8'h00);
    settle();

    // height above the maximum saturates, rows continue across a change
    apply_settings(7'd2, 7'd127, 7'd0, 7'd0);
    offer_byte(8'hE7, 8'h00);
    offer_byte(8'h7E, 8'h00);
    settle();
    apply_settings(7'd3, 7'd64, 7'd1, 7'd0);
    offer_byte(8'h81, 8'h00);
    offer_byte(8'h42, 8'h00);
    offer_byte(8'h24, 8'h00);
    settle();

    // fewer byte rows than the row counter restarts it
    apply_settings(7'd2, 7'd12, 7'd0, 7'd0);
    offer_byte(8'h18, 8'h00);
    offer_byte(8'hDB, 8'h00);
    settle();

    // random phases: mostly whole glyphs, some broken off part way
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      w = 0;
      else if (pick == 1) w = 63;
      else if (pick == 2) w = $urandom_range(9, 62);
      else                w = $urandom_range(1, 8);
      pick = $urandom_range(0, 19);
      if (pick == 0)      h = 0;
      else if (pick == 1) h = 64;
      else if (pick == 2) h = $urandom_range(65, 127);
      else if (pick == 3) h = $urandom_range(25, 63);
      else                h = $urandom_range(1, 24);
      width_data  = {1'($urandom_range(0, 1)), 6'(w)};
      height_data = 7'(h);
      apply_settings(width_data, height_data,
                     {6'($urandom), 1'($urandom_range(0, 1))},
                     {6'($urandom), 1'($urandom_range(0, 1))});

      if (w == 0) w = 1;
      if (h == 0) h = 1;
      if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
      rows = (h + 7) / 8;
      if (w * rows > 70) count = w;
      else               count = w * rows * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);

      // long receiver hold-off while requests keep coming
      if (phase == 2) begin
        if (count < 40) count = 40;
        hold_request = 1'b1;
      end

      // keep the total near the target
      if (random_items + count > RANDOM_ITEMS) count = RANDOM_ITEMS - random_items;

      repeat (count) offer_byte(8'($urandom), 8'($urandom));
      random_items += count;
      settle();
      phase++;
      if (random_items + CALM_TAIL >= RANDOM_ITEMS) calm = 1'b1;
    end

    settle();
    repeat (2 * MAX_WIDTH_DEF + 8) @(posedge clk);
    if (tracker.mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/ggpf_pkg.sv
rtl/ggpf_in_if.sv
rtl/ggpf_out_if.sv
rtl/ggpf_cfg_if.sv
rtl/ggpf_ram.sv
rtl/ggpf_ctrl.sv
rtl/ggpf_datapath.sv
rtl/glyph_to_gray_page_formatter.sv
verif/ggpf_check_pkg.sv
verif/tb_glyph_to_gray_page_formatter.sv
